@@ rtl/bounded_ring_deque_top_assert.svh @@
// Assertion macros for the bounded ring deque checker.
// Expects clk and rst_n in scope where a macro is used.
`ifndef BOUNDED_RING_DEQUE_TOP_ASSERT_SVH
`define BOUNDED_RING_DEQUE_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define BRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/brd_pkg.sv @@
// Shared types and constants for the bounded ring deque.
// No dependencies.
`timescale 1ns / 1ps

package brd_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned HELD_W   = 7;
    localparam int unsigned STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT      = 3'd4;
    localparam logic [OP_W-1:0] OP_VISIT      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic visit_start;
        logic visit_step;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic single;
        logic step_last;
    } sts_t;

endpackage

@@ rtl/brd_ctrl.sv @@
// Request sequencer for the bounded ring deque: decodes requests, issues datapath commands,
// drives the result strobe, status and last flag. Depends on brd_pkg.
`timescale 1ns / 1ps

module brd_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [brd_pkg::OP_W-1:0]      op,
    input  brd_pkg::sts_t                 sts,
    output brd_pkg::cmd_t                 cmd,
    output logic                          busy,
    output logic                          strobe,
    output logic [brd_pkg::STATUS_W-1:0]  status,
    output logic                          last
);
    import brd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_VISIT
    } state_t;

    state_t                state_reg;
    logic                  strobe_reg;
    logic                  last_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic                  accept;
    state_t                acc_state;
    logic [STATUS_W-1:0]   acc_status;
    logic                  acc_last;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        acc_state  = S_RESP;
        acc_status = ST_OK;
        acc_last   = 1'b1;
        cmd.accept = accept;
        if (accept)
        begin
            unique case (op)
                OP_PUSH_FRONT:
                begin
                    if (sts.full)
                    begin
                        acc_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.push_front = 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (sts.full)
                    begin
                        acc_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.push_back = 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (sts.empty)
                    begin
                        acc_status = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.pop_front = 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (sts.empty)
                    begin
                        acc_status = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.pop_back = 1'b1;
                    end
                end
                OP_VISIT:
                begin
                    if (sts.empty)
                    begin
                        acc_status = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.visit_start = 1'b1;
                        acc_state       = S_VISIT;
                        acc_last        = sts.single;
                    end
                end
                default:
                begin
                end
            endcase
        end
        // advance the walk until the final word is out
        if ((state_reg == S_VISIT) && !last_reg)
        begin
            cmd.visit_step = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg  <= acc_state;
                        strobe_reg <= 1'b1;
                        status_reg <= acc_status;
                        last_reg   <= acc_last;
                    end
                end
                S_RESP:
                begin
                    state_reg  <= S_IDLE;
                    strobe_reg <= 1'b0;
                end
                S_VISIT:
                begin
                    if (last_reg)
                    begin
                        state_reg  <= S_IDLE;
                        strobe_reg <= 1'b0;
                    end
                    else
                    begin
                        last_reg <= sts.step_last;
                    end
                end
                default:
                begin
                    state_reg  <= S_IDLE;
                    strobe_reg <= 1'b0;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign status = status_reg;
    assign last   = last_reg;

endmodule

@@ rtl/brd_dp.sv @@
// Datapath for the bounded ring deque: word store, front index, entry count and walk index.
// Depends on brd_pkg; driven by brd_ctrl commands.
`timescale 1ns / 1ps

module brd_dp #(
    parameter int unsigned DEPTH = brd_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  brd_pkg::cmd_t                       cmd,
    input  logic signed [brd_pkg::DATA_W-1:0]   value,
    output brd_pkg::sts_t                       sts,
    output logic signed [brd_pkg::DATA_W-1:0]   data,
    output logic [brd_pkg::HELD_W-1:0]          held
);
    import brd_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] store_mem [DEPTH];

    logic [IW-1:0]            front_reg;
    logic [IW-1:0]            front_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [IW-1:0]            walk_reg;
    logic [IW-1:0]            walk_next;
    logic                     sel_mem_reg;
    logic signed [DATA_W-1:0] rd_data_reg;

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic                     rd_en;
    logic [IW-1:0]            rd_addr;
    logic [IW-1:0]            walk_inc;
    logic [IW-1:0]            front_dec;

    // ring position (base + offset) mod DEPTH, both operands below DEPTH
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [IW-1:0] offset);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (IW+1)'(DEPTH))
        begin
            sum = sum - (IW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign walk_inc  = walk_reg + IW'(1);
    assign front_dec = ring_add(front_reg, IW'(DEPTH - 1));

    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = front_dec;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        front_next = front_reg;
        count_next = count_reg;
        walk_next  = walk_reg;
        priority if (cmd.push_front)
        begin
            wr_en      = 1'b1;
            wr_addr    = front_dec;
            front_next = front_dec;
            count_next = count_reg + CW'(1);
        end
        else if (cmd.push_back)
        begin
            wr_en      = 1'b1;
            wr_addr    = ring_add(front_reg, count_reg[IW-1:0]);
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop_front)
        begin
            rd_en      = 1'b1;
            rd_addr    = front_reg;
            front_next = ring_add(front_reg, IW'(1));
            count_next = count_reg - CW'(1);
        end
        else if (cmd.pop_back)
        begin
            rd_en      = 1'b1;
            rd_addr    = ring_add(front_reg, IW'(count_reg - CW'(1)));
            count_next = count_reg - CW'(1);
        end
        else if (cmd.visit_start)
        begin
            rd_en     = 1'b1;
            rd_addr   = front_reg;
            walk_next = '0;
        end
        else if (cmd.visit_step)
        begin
            rd_en     = 1'b1;
            rd_addr   = ring_add(front_reg, walk_inc);
            walk_next = walk_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg   <= '0;
            count_reg   <= '0;
            walk_reg    <= '0;
            sel_mem_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
            if (cmd.accept)
            begin
                sel_mem_reg <= cmd.pop_front || cmd.pop_back || cmd.visit_start;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CW'(DEPTH));
    assign sts.single    = (count_reg == CW'(1));
    assign sts.step_last = ((CW+1)'(walk_reg) + (CW+1)'(2)) == (CW+1)'(count_reg);

    assign data = sel_mem_reg ? rd_data_reg : '0;
    assign held = HELD_W'(count_reg);

endmodule

@@ rtl/bounded_ring_deque_top.sv @@
// Top level of the bounded ring deque of signed 32-bit words.
// Depends on brd_pkg, brd_ctrl and brd_dp.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Push, pop, count and any other
// code give one result in the cycle after the request; visit on a non-empty deque gives
// one result per held word, front first, in consecutive cycles, read through the
// registered read port of the word store. Results appear on data, held, status and last
// for exactly one cycle with strobe high and are never held back: the receiver must take
// every strobe. busy stays high from the request until the cycle of its last result.
module bounded_ring_deque_top #(
    parameter int unsigned DEPTH = brd_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [brd_pkg::OP_W-1:0]            op,
    input  logic signed [brd_pkg::DATA_W-1:0]   value,
    output logic                                strobe,
    output logic signed [brd_pkg::DATA_W-1:0]   data,
    output logic [brd_pkg::HELD_W-1:0]          held,
    output logic [brd_pkg::STATUS_W-1:0]        status,
    output logic                                last
);
    import brd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    brd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe),
        .status (status),
        .last   (last)
    );

    brd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .value (value),
        .sts   (sts),
        .data  (data),
        .held  (held)
    );

endmodule

@@ rtl/brd_chk.sv @@
// Port-level checker for the bounded ring deque, bound to the top level.
// Depends on brd_pkg and bounded_ring_deque_top_assert.svh.
`timescale 1ns / 1ps
`include "bounded_ring_deque_top_assert.svh"

module brd_chk #(
    parameter int unsigned DEPTH = brd_pkg::DEPTH_DEFAULT
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                strobe,
    input logic signed [brd_pkg::DATA_W-1:0]   data,
    input logic [brd_pkg::HELD_W-1:0]          held,
    input logic [brd_pkg::STATUS_W-1:0]        status,
    input logic                                last
);
    import brd_pkg::*;

    `BRD_ASSERT_NEXT(a_req_gives_result, start && !busy, strobe, "request without result")
    `BRD_ASSERT_NEXT(a_visit_continues, strobe && !last, strobe && busy, "result burst broken")
    `BRD_ASSERT_NEXT(a_last_ends_burst, strobe && last, !strobe && !busy, "result after last")
    `BRD_ASSERT_NOW(a_error_is_single, strobe && status != ST_OK, last && data == '0, "bad error")
    `BRD_ASSERT_NOW(a_held_in_range, strobe, held <= HELD_W'(DEPTH), "held above depth")

endmodule

bind bounded_ring_deque_top brd_chk #(
    .DEPTH (DEPTH)
) u_brd_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .data   (data),
    .held   (held),
    .status (status),
    .last   (last)
);
